/* sv/ipid_pkg.sv */
// Shared types, widths and codes for the incremental PID controller.
`timescale 1ns / 1ps
package ipid_pkg;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd5;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_PRESET = 1'b1;

	localparam logic [14:0] LIMIT_RESET = 15'd32767;
	localparam logic [15:0] RATE_RESET  = 16'd66;

	localparam int MUL_A_W = 37;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DELTA_W = 37;
	localparam int FRAC_SH = 8;
	localparam int SUM_W   = PROD_W - FRAC_SH + 1;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_AW    = 1;
	localparam int CQ_CW    = 2;

	typedef struct packed {
		logic signed [15:0] gain_pt;
		logic signed [15:0] gain_pm;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [14:0]        limit;
		logic [15:0]        rate;
	} cfg_t;

	typedef struct packed {
		logic               is_preset;
		logic signed [31:0] preset_value;
		logic signed [16:0] d_target;
		logic signed [16:0] d_meas;
		logic signed [16:0] err;
		logic signed [17:0] second;
	} cmd_t;

endpackage

/* sv/ipid_front.sv */
// Front end: accepts requests, keeps sample history, forms the differences.
`timescale 1ns / 1ps
module ipid_front import ipid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               req_type,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] measured,
	input  logic signed [31:0] preset_value,
	input  logic               q_full,
	output logic               full,
	output logic               cq_push,
	output cmd_t               cq_cmd
);

	logic signed [15:0] prior_sp_q;
	logic signed [15:0] prior_ms_q;
	logic signed [15:0] older_ms_q;
	logic               accept;

	assign accept  = push && !q_full;
	assign full    = q_full;
	assign cq_push = accept;

	always_comb begin
		cq_cmd.is_preset    = (req_type == REQ_PRESET);
		cq_cmd.preset_value = preset_value;
		cq_cmd.d_target     = 17'(setpoint) - 17'(prior_sp_q);
		cq_cmd.d_meas       = 17'(measured) - 17'(prior_ms_q);
		cq_cmd.err          = 17'(setpoint) - 17'(measured);
		cq_cmd.second       = 18'(measured) - (18'(prior_ms_q) <<< 1) + 18'(older_ms_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_sp_q <= '0;
			prior_ms_q <= '0;
			older_ms_q <= '0;
		end else if (accept && req_type == REQ_UPDATE) begin
			prior_sp_q <= setpoint;
			older_ms_q <= prior_ms_q;
			prior_ms_q <= measured;
		end
	end

endmodule

/* sv/ipid_cmd_queue.sv */
// Two-entry command queue between front end and execution unit.
`timescale 1ns / 1ps
module ipid_cmd_queue import ipid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	input  logic rd_en,
	output logic full,
	output logic valid,
	output cmd_t rd_cmd
);

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (count_q == CQ_CW'(CQ_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_cmd = mem_q[rd_ptr_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + CQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + CQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CQ_CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CQ_CW'(1);
			end
		end
	end

endmodule

/* sv/ipid_back.sv */
// Execution unit: shared multiplier sequence, scaling, accumulate, clamp, result register.
`timescale 1ns / 1ps
module ipid_back import ipid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               cq_valid,
	input  cmd_t               cq_cmd,
	output logic               cq_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] drive
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_T0    = 3'd1;
	localparam logic [2:0] ST_T1    = 3'd2;
	localparam logic [2:0] ST_T2    = 3'd3;
	localparam logic [2:0] ST_T3    = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;
	localparam logic [2:0] ST_SCALE = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]                 state_q;
	cmd_t                       cmd_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DELTA_W-1:0]  delta_q;
	logic signed [31:0]         acc_q;
	logic signed [31:0]         out_q;
	logic                       out_valid_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [DELTA_W-1:0]  term;
	logic signed [SUM_W-2:0]    scaled;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    lim;
	logic signed [31:0]         new_val;
	logic                       fin_wr;

	assign empty  = !out_valid_q;
	assign drive  = out_q;
	assign cq_pop = (state_q == ST_IDLE) && cq_valid;
	assign fin_wr = (state_q == ST_FIN) && (!out_valid_q || pop);
	assign term   = $signed(prod_q[DELTA_W-1:0]);

	always_comb begin
		case (state_q)
			ST_T0: begin
				mul_a = MUL_A_W'(cmd_q.d_target);
				mul_b = MUL_B_W'(cfg.gain_pt);
			end
			ST_T1: begin
				mul_a = MUL_A_W'(cmd_q.d_meas);
				mul_b = MUL_B_W'(cfg.gain_pm);
			end
			ST_T2: begin
				mul_a = MUL_A_W'(cmd_q.err);
				mul_b = MUL_B_W'(cfg.gain_i);
			end
			ST_T3: begin
				mul_a = MUL_A_W'(cmd_q.second);
				mul_b = MUL_B_W'(cfg.gain_d);
			end
			default: begin
				mul_a = MUL_A_W'(delta_q);
				mul_b = $signed({1'b0, cfg.rate});
			end
		endcase
	end

	// floor shift to Q16.16, then accumulate and clamp; a preset takes its preset value unclamped
	always_comb begin
		scaled = $signed(prod_q[PROD_W-1:FRAC_SH]);
		sum    = SUM_W'(acc_q) + SUM_W'(scaled);
		lim    = $signed(SUM_W'({cfg.limit, 16'h0000}));
		if (cmd_q.is_preset) begin
			new_val = cmd_q.preset_value;
		end else if (sum > lim) begin
			new_val = lim[31:0];
		end else if (sum < -lim) begin
			new_val = 32'(-lim);
		end else begin
			new_val = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cq_pop) begin
			cmd_q <= cq_cmd;
		end
		case (state_q)
			ST_T1:   delta_q <= term;
			ST_T2:   delta_q <= delta_q - term;
			ST_T3:   delta_q <= delta_q + term;
			ST_SUM:  delta_q <= delta_q + term;
			default: delta_q <= delta_q;
		endcase
		if (fin_wr) begin
			out_q <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cq_valid) begin
						state_q <= cq_cmd.is_preset ? ST_FIN : ST_T0;
					end
				end
				ST_T0:    state_q <= ST_T1;
				ST_T1:    state_q <= ST_T2;
				ST_T2:    state_q <= ST_T3;
				ST_T3:    state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_wr) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
			if (fin_wr) begin
				acc_q       <= new_val;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/incremental_pid_controller.sv */
// Top level of the incremental PID controller: config registers and unit wiring.
//
//   channel   direction  handshake                 payload
//   request   in         push / full               req_type, setpoint, measured, preset_value
//   result    out        pop / empty               drive
//   config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An update in the execution unit passes a dequeue state, four gain products through
// one shared multiplier, one drain of the product register, a scale product through the
// same multiplier and an accumulate-and-clamp state. A preset goes from dequeue to the final state.
// Reset clears history, accumulator, queues and loads the config defaults.
// A two-entry request queue keeps accepting while the result register waits on pop.
`timescale 1ns / 1ps
module incremental_pid_controller import ipid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 req_type,
	input  logic signed [15:0]   setpoint,
	input  logic signed [15:0]   measured,
	input  logic signed [31:0]   preset_value,
	output logic                 empty,
	input  logic                 pop,
	output logic signed [31:0]   drive,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic cq_push;
	cmd_t cq_wr_cmd;
	logic cq_valid;
	logic cq_pop;
	cmd_t cq_rd_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_pt <= '0;
			cfg_q.gain_pm <= '0;
			cfg_q.gain_i  <= '0;
			cfg_q.gain_d  <= '0;
			cfg_q.limit   <= LIMIT_RESET;
			cfg_q.rate    <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_PT: cfg_q.gain_pt <= $signed(cfg_data);
				REG_GAIN_PM: cfg_q.gain_pm <= $signed(cfg_data);
				REG_GAIN_I:  cfg_q.gain_i  <= $signed(cfg_data);
				REG_GAIN_D:  cfg_q.gain_d  <= $signed(cfg_data);
				REG_LIMIT:   cfg_q.limit   <= cfg_data[14:0];
				REG_RATE:    cfg_q.rate    <= cfg_data;
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	ipid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.req_type     (req_type),
		.setpoint     (setpoint),
		.measured     (measured),
		.preset_value (preset_value),
		.q_full       (q_full),
		.full         (full),
		.cq_push      (cq_push),
		.cq_cmd       (cq_wr_cmd)
	);

	ipid_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cq_push),
		.wr_cmd (cq_wr_cmd),
		.rd_en  (cq_pop),
		.full   (q_full),
		.valid  (cq_valid),
		.rd_cmd (cq_rd_cmd)
	);

	ipid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cq_valid (cq_valid),
		.cq_cmd   (cq_rd_cmd),
		.cq_pop   (cq_pop),
		.pop      (pop),
		.empty    (empty),
		.drive    (drive)
	);

endmodule

/* sv/ipid_checker.sv */
// Port-level checker for the incremental PID controller, bound to the top level.
`timescale 1ns / 1ps
module ipid_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input logic                 empty,
	input logic                 pop,
	input logic signed [31:0]   drive,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without pop");

	a_drive_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(drive))
		else $error("drive changed while stalled");

	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("queues not clear after reset");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a request");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind incremental_pid_controller ipid_checker u_ipid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.drive     (drive),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
